### rtl/core/otsu_pkg.sv
// shared constants, request types and controller/datapath interface for the otsu threshold block
package otsu_pkg;

  localparam int unsigned MaxPixels = 65536;
  localparam int unsigned Levels    = 256;
  localparam int unsigned LvlW      = 8;
  localparam int unsigned CntW      = $clog2(MaxPixels + 1);
  localparam int unsigned SumW      = CntW + LvlW;
  localparam int unsigned DiffW     = CntW + SumW;
  localparam int unsigned DenW      = 2 * CntW;
  localparam int unsigned SqW       = 2 * DiffW;
  localparam int unsigned ProdW     = SqW + DenW;
  localparam int unsigned MulYW     = (DiffW > DenW) ? DiffW : DenW;

  typedef struct packed {
    logic [7:0] pixel;
    logic       last;
  } pix_req_t;

  typedef struct packed {
    logic [7:0] threshold;
    logic       overflow;
  } thr_req_t;

  typedef enum logic [1:0] {
    MulSq,
    MulLhs,
    MulRhs
  } mul_sel_e;

  typedef struct packed {
    logic     push;
    logic     clear;
    logic     init;
    logic     rd;
    logic     acc;
    logic     ab;
    logic     diff;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     cap_sq;
    logic     cap_lhs;
    logic     take;
    logic     next;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic skip;
    logic best_zero;
    logic diff_zero;
    logic gt;
    logic last_level;
  } dp_stat_t;

endpackage

### rtl/core/otsu_dp.sv
// otsu datapath: histogram memory, running sums, scan registers and serial multiplier
module otsu_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  otsu_pkg::dp_cmd_t cmd_i,
  input  logic [7:0]        pixel_i,
  output otsu_pkg::dp_stat_t stat_o,
  output logic [7:0]        level_o,
  output logic              overflow_o
);
  import otsu_pkg::*;

  logic [CntW-1:0]  hist_mem [Levels];
  logic [Levels-1:0] hv_q;
  logic [CntW-1:0]  rd_q;
  logic             rv_q;
  logic [LvlW-1:0]  p1_q;
  logic             v1_q;
  logic             fw_v_q;
  logic [LvlW-1:0]  fw_a_q;
  logic [CntW-1:0]  fw_d_q;
  logic [CntW-1:0]  cur, wdata, h;
  logic [LvlW-1:0]  rd_addr;
  logic             room;

  logic [CntW-1:0]  n_q, c0_q;
  logic [SumW-1:0]  st_q, s0_q;
  logic             ovf_q;
  logic [LvlW-1:0]  level_q, best_lvl_q;
  logic [DiffW-1:0] a_q, b_q, diff_q;
  logic [DenW-1:0]  den_q, best_den_q;
  logic [SqW-1:0]   sq_q, best_sq_q;
  logic [ProdW-1:0] lhs_q, mx_q, acc_q;
  logic [MulYW-1:0] my_q;

  assign rd_addr = cmd_i.push ? pixel_i : level_q;
  assign room    = (n_q < CntW'(MaxPixels));

  // forward the write of the previous cycle for repeated pixels
  assign cur   = (fw_v_q && (fw_a_q == p1_q)) ? fw_d_q : (rv_q ? rd_q : '0);
  assign wdata = cur + CntW'(1);
  assign h     = rv_q ? rd_q : '0;

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      hist_mem[p1_q] <= wdata;
    end
    if (cmd_i.push || cmd_i.rd) begin
      rd_q <= hist_mem[rd_addr];
      rv_q <= hv_q[rd_addr];
    end
    p1_q   <= pixel_i;
    fw_a_q <= p1_q;
    fw_d_q <= wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q   <= '0;
      v1_q   <= 1'b0;
      fw_v_q <= 1'b0;
      n_q    <= '0;
      st_q   <= '0;
      ovf_q  <= 1'b0;
    end else begin
      v1_q   <= cmd_i.push && room;
      fw_v_q <= v1_q;
      if (cmd_i.clear) begin
        hv_q  <= '0;
        n_q   <= '0;
        st_q  <= '0;
        ovf_q <= 1'b0;
      end else begin
        if (v1_q) begin
          hv_q[p1_q] <= 1'b1;
        end
        if (cmd_i.push) begin
          if (room) begin
            n_q  <= n_q + CntW'(1);
            st_q <= st_q + SumW'(pixel_i);
          end else begin
            ovf_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q    <= '0;
      best_lvl_q <= '0;
      best_den_q <= '0;
    end else begin
      if (cmd_i.init) begin
        level_q    <= '0;
        best_lvl_q <= '0;
        best_den_q <= '0;
      end else begin
        if (cmd_i.next) begin
          level_q <= level_q + LvlW'(1);
        end
        if (cmd_i.take) begin
          best_den_q <= den_q;
          best_lvl_q <= level_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      c0_q      <= '0;
      s0_q      <= '0;
      best_sq_q <= '0;
    end else begin
      if (cmd_i.acc) begin
        c0_q <= c0_q + h;
        s0_q <= s0_q + SumW'(level_q) * SumW'(h);
      end
      if (cmd_i.take) begin
        best_sq_q <= sq_q;
      end
    end
    if (cmd_i.ab) begin
      a_q   <= DiffW'(st_q) * DiffW'(c0_q);
      b_q   <= DiffW'(n_q) * DiffW'(s0_q);
      den_q <= DenW'(c0_q) * DenW'(n_q - c0_q);
    end
    if (cmd_i.diff) begin
      diff_q <= (a_q >= b_q) ? (a_q - b_q) : (b_q - a_q);
    end
    if (cmd_i.cap_sq) begin
      sq_q <= acc_q[SqW-1:0];
    end
    if (cmd_i.cap_lhs) begin
      lhs_q <= acc_q;
    end
  end

  // shift-add multiplier, one multiplier bit per cycle, stops when it runs out of ones
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      my_q  <= '0;
      mx_q  <= '0;
      acc_q <= '0;
    end else if (cmd_i.mul_start) begin
      acc_q <= '0;
      case (cmd_i.mul_sel)
        MulLhs: begin
          mx_q <= ProdW'(sq_q);
          my_q <= MulYW'(best_den_q);
        end
        MulRhs: begin
          mx_q <= ProdW'(best_sq_q);
          my_q <= MulYW'(den_q);
        end
        default: begin
          mx_q <= ProdW'(diff_q);
          my_q <= MulYW'(diff_q);
        end
      endcase
    end else if (my_q != '0) begin
      if (my_q[0]) begin
        acc_q <= acc_q + mx_q;
      end
      mx_q <= mx_q << 1;
      my_q <= my_q >> 1;
    end
  end

  assign stat_o.busy       = (my_q != '0);
  assign stat_o.skip       = (c0_q == '0) || (c0_q >= n_q);
  assign stat_o.best_zero  = (best_den_q == '0);
  assign stat_o.diff_zero  = (diff_q == '0);
  assign stat_o.gt         = (lhs_q > acc_q);
  assign stat_o.last_level = (level_q == LvlW'(Levels - 1));

  assign level_o    = best_lvl_q;
  assign overflow_o = ovf_q;

endmodule

### rtl/core/otsu_ctrl.sv
// otsu controller: pixel intake, per-level scan sequencing and result handoff
module otsu_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_last_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  otsu_pkg::dp_stat_t stat_i,
  output otsu_pkg::dp_cmd_t  cmd_o
);
  import otsu_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DRAIN = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_ACC   = 4'd3;
  localparam logic [3:0] S_AB    = 4'd4;
  localparam logic [3:0] S_DIFF  = 4'd5;
  localparam logic [3:0] S_SQ    = 4'd6;
  localparam logic [3:0] S_SQW   = 4'd7;
  localparam logic [3:0] S_CHK   = 4'd8;
  localparam logic [3:0] S_LHS   = 4'd9;
  localparam logic [3:0] S_LHSW  = 4'd10;
  localparam logic [3:0] S_RHS   = 4'd11;
  localparam logic [3:0] S_RHSW  = 4'd12;
  localparam logic [3:0] S_NEXT  = 4'd13;
  localparam logic [3:0] S_OUT   = 4'd14;

  logic [3:0] state_q, state_d;
  logic       push;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign push        = in_valid_i && !in_stall_o;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.mul_sel = MulSq;
    cmd_o.push    = push;
    unique case (state_q)
      S_IDLE: begin
        if (push && in_last_i) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd_o.init = 1'b1;
        state_d    = S_RD;
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = S_AB;
      end
      S_AB: begin
        cmd_o.ab = 1'b1;
        state_d  = S_DIFF;
      end
      S_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = stat_i.skip ? S_NEXT : S_SQ;
      end
      S_SQ: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MulSq;
        state_d         = S_SQW;
      end
      S_SQW: begin
        if (!stat_i.busy) begin
          cmd_o.cap_sq = 1'b1;
          state_d      = S_CHK;
        end
      end
      S_CHK: begin
        if (stat_i.best_zero) begin
          cmd_o.take = !stat_i.diff_zero;
          state_d    = S_NEXT;
        end else begin
          state_d = S_LHS;
        end
      end
      S_LHS: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MulLhs;
        state_d         = S_LHSW;
      end
      S_LHSW: begin
        if (!stat_i.busy) begin
          cmd_o.cap_lhs = 1'b1;
          state_d       = S_RHS;
        end
      end
      S_RHS: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MulRhs;
        state_d         = S_RHSW;
      end
      S_RHSW: begin
        if (!stat_i.busy) begin
          cmd_o.take = stat_i.gt;
          state_d    = S_NEXT;
        end
      end
      S_NEXT: begin
        cmd_o.next = 1'b1;
        state_d    = stat_i.last_level ? S_OUT : S_RD;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          cmd_o.clear = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && in_last_i) |=> in_stall_o)
    else $error("pixel taken right after last pixel");

  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while result pending");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) |=> !out_valid_o)
    else $error("result repeated");

  a_take_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take |-> !stat_i.busy)
    else $error("best level updated while multiplier running");

endmodule

### rtl/core/otsu_threshold_core.sv
// otsu threshold top level: one 8-bit pixel per cycle in when not stalled, one threshold per image out
// pixels are taken one per cycle while not stalled; the pixel marked last starts a scan of all 256 levels
// levels with an empty class are skipped, and a scored level takes longer, its time set by the
// shift-add multiplier (one multiplier bit per cycle)
// input is stalled from the last pixel until the result request is taken
// asynchronous active-low reset clears the histogram valid bits, counts and controller
module otsu_threshold_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  otsu_pkg::pix_req_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output otsu_pkg::thr_req_t out_data_o
);
  import otsu_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [7:0] level;
  logic       ovf;

  otsu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_data_i.last),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  otsu_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .pixel_i    (in_data_i.pixel),
    .stat_o     (stat),
    .level_o    (level),
    .overflow_o (ovf)
  );

  assign out_data_o.threshold = level;
  assign out_data_o.overflow  = ovf;

endmodule

### tb/tb.sv
// testbench for the otsu threshold core: streams images and checks each threshold
`timescale 1ns / 100ps
module tb;
  import otsu_pkg::*;

  localparam int unsigned CycleLimit = 12_000_000;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  pix_req_t in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  thr_req_t out_data_o;

  otsu_threshold_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // predictor state
  longint unsigned hist_q[Levels];
  longint unsigned pix_count;
  longint unsigned level_sum;
  bit              ovf_seen;
  thr_req_t        thresholds_q[$];

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned mismatches;
  longint unsigned cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic void clear_image();
    for (int i = 0; i < Levels; i++) hist_q[i] = 0;
    pix_count = 0;
    level_sum = 0;
    ovf_seen  = 1'b0;
  endfunction

  // true if cd^2/cden > bd^2/bden
  function automatic bit score_above(longint unsigned cd, longint unsigned cden,
                                     longint unsigned bd, longint unsigned bden);
    logic [127:0] lhs;
    logic [127:0] rhs;
    lhs = 128'(cd) * 128'(cd) * 128'(bden);
    rhs = 128'(bd) * 128'(bd) * 128'(cden);
    return lhs > rhs;
  endfunction

  function automatic void predict_threshold(pix_req_t req);
    longint unsigned c0, s0, c1, a, b, d, den, best_d, best_den;
    logic [7:0] best_lvl;
    thr_req_t   res;
    if (pix_count < MaxPixels) begin
      hist_q[req.pixel]++;
      pix_count++;
      level_sum += req.pixel;
    end else begin
      ovf_seen = 1'b1;
    end
    if (!req.last) return;
    c0 = 0; s0 = 0; best_d = 0; best_den = 0; best_lvl = '0;
    for (int lvl = 0; lvl < Levels; lvl++) begin
      c0 += hist_q[lvl];
      s0 += longint'(lvl) * hist_q[lvl];
      if (c0 == 0 || c0 >= pix_count) continue;
      c1  = pix_count - c0;
      a   = level_sum * c0;
      b   = pix_count * s0;
      d   = (a >= b) ? a - b : b - a;
      den = c0 * c1;
      if (best_den == 0) begin
        if (d != 0) begin
          best_d = d; best_den = den; best_lvl = 8'(lvl);
        end
      end else if (score_above(d, den, best_d, best_den)) begin
        best_d = d; best_den = den; best_lvl = 8'(lvl);
      end
    end
    res.threshold = best_lvl;
    res.overflow  = ovf_seen;
    thresholds_q.push_back(res);
    clear_image();
  endfunction

  // result side: random stall and compare against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    thr_req_t exp_res;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (thresholds_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected threshold %0d ovf %0d", out_data_o.threshold,
                     out_data_o.overflow);
        end else begin
          exp_res = thresholds_q.pop_front();
          if (out_data_o.threshold !== exp_res.threshold ||
              out_data_o.overflow !== exp_res.overflow) begin
            mismatches++;
            if (mismatches <= 10)
              $display("threshold mismatch: exp %0d/%0d got %0d/%0d",
                       exp_res.threshold, exp_res.overflow,
                       out_data_o.threshold, out_data_o.overflow);
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_pixel(logic [7:0] pix, logic lst);
    pix_req_t req;
    req.pixel = pix;
    req.last  = lst;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    predict_threshold(req);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (thresholds_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_pixel(8'd0, 1'b1);                       // single pixel, empty class
    send_pixel(8'd255, 1'b0); send_pixel(8'd255, 1'b1);  // all equal
    send_pixel(8'd0, 1'b0); send_pixel(8'd255, 1'b1);    // extremes
    send_pixel(8'd254, 1'b0); send_pixel(8'd255, 1'b1);
    // ties: symmetric distribution
    send_pixel(8'd10, 1'b0); send_pixel(8'd20, 1'b0);
    send_pixel(8'd30, 1'b0); send_pixel(8'd40, 1'b1);
    send_pixel(8'd100, 1'b0); send_pixel(8'd100, 1'b0);
    send_pixel(8'd101, 1'b0); send_pixel(8'd200, 1'b0);
    send_pixel(8'd170, 1'b0); send_pixel(8'd85, 1'b1);
    // pause until the result is back, then send again
    wait_drained();
    send_pixel(8'd1, 1'b0); send_pixel(8'd128, 1'b0); send_pixel(8'd127, 1'b1);
    wait_drained();
  endtask

  task automatic test_random(int unsigned items);
    int unsigned sent, len, base, span;
    sent = 0;
    while (sent < items) begin
      len  = ($urandom_range(9) == 0) ? $urandom_range(200, 60) : $urandom_range(30, 1);
      span = ($urandom_range(3) == 0) ? 255 : $urandom_range(40, 0);
      base = $urandom_range(255 - span);
      for (int i = 0; i < len; i++)
        send_pixel(8'(base + $urandom_range(span)), i == len - 1);
      sent += len;
    end
    wait_drained();
  endtask

  initial begin
    cycles      = 0;
    mismatches  = 0;
    idle_pct    = 0;
    stall_pct   = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    clear_image();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(260);
    idle_pct = 69; stall_pct = 0;
    test_random(260);
    idle_pct = 0; stall_pct = 69;
    test_random(260);
    idle_pct = 37; stall_pct = 37;
    test_random(260);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && thresholds_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
